[hw/rtl/lbphe_pkg.sv]
`default_nettype none

package lbphe_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int COUNT_BITS_DEF = 20;

    // Clamped frame sizes and positions are compared at this width.
    localparam int SIZE_BITS = 13;

    localparam int OUT_BITS = 20;
    localparam logic [OUT_BITS-1:0] OUT_COUNT_MAX = 20'hFFFFF;

    localparam logic [7:0] UNI_BINS     = 8'd58;
    localparam logic [7:0] BIN_FLAT     = 8'd56;
    localparam logic [7:0] BIN_NONUNI   = 8'd57;
    localparam logic [7:0] CODE_ONES    = 8'hff;
    localparam int         RUN_LEN_MAX  = 7;

    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_UNIFORM_MODE = 2'd2;

    // A pixel on its way from the line store read to the code stage.
    typedef struct packed {
        logic       vld;
        logic       interior;
        logic [7:0] px;
    } push_t;

    // A histogram increment request.
    typedef struct packed {
        logic       vld;
        logic [7:0] bin;
    } hist_upd_t;

    // Uniform mapping: a rotated run of j ones starting at bit i goes to bin i*7+j-1.
    function automatic logic [7:0] uniform_bin(input logic [7:0] code);
        logic [7:0]  bin;
        logic [7:0]  base;
        logic [15:0] shifted;
        logic [7:0]  run;
        bin = BIN_NONUNI;
        if (code == 8'd0 || code == CODE_ONES) begin
            bin = BIN_FLAT;
        end else begin
            for (int i = 0; i < 8; i++) begin
                for (int j = 1; j <= RUN_LEN_MAX; j++) begin
                    base    = 8'((9'd1 << j) - 9'd1);
                    shifted = {8'd0, base} << i;
                    run     = shifted[7:0] | shifted[15:8];
                    if (run == code) begin
                        bin = 8'(i * RUN_LEN_MAX + j - 1);
                    end
                end
            end
        end
        return bin;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/lbphe_line_store.sv]
`default_nettype none

module lbphe_line_store
    import lbphe_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          wr_en,
    input  wire logic          sel,
    input  wire logic [CW-1:0] col,
    input  wire logic [7:0]    px,
    output logic [7:0]         top,
    output logic [7:0]         mid,
    output logic               clr_busy
);

    // Bank k holds the row whose index has bit 0 equal to k.
    logic [7:0] bank0_mem [MAX_WIDTH];
    logic [7:0] bank1_mem [MAX_WIDTH];

    logic [7:0]    rd0_reg;
    logic [7:0]    rd1_reg;
    logic          sel_reg;
    logic          clr_busy_reg;
    logic [CW-1:0] clr_addr_reg;

    logic          we0;
    logic          we1;
    logic [CW-1:0] waddr;
    logic [7:0]    wdata;

    assign we0   = clr_busy_reg || (wr_en && !sel);
    assign we1   = clr_busy_reg || (wr_en && sel);
    assign waddr = clr_busy_reg ? clr_addr_reg : col;
    assign wdata = clr_busy_reg ? 8'd0 : px;

    always_ff @(posedge aclk) begin
        if (we0) begin
            bank0_mem[waddr] <= wdata;
        end
        rd0_reg <= bank0_mem[col];
    end

    always_ff @(posedge aclk) begin
        if (we1) begin
            bank1_mem[waddr] <= wdata;
        end
        rd1_reg <= bank1_mem[col];
    end

    always_ff @(posedge aclk) begin
        sel_reg <= sel;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            if (clr_addr_reg == CW'(MAX_WIDTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + CW'(1);
        end
    end

    // The bank being overwritten holds row r-2; the other holds row r-1.
    assign top      = sel_reg ? rd1_reg : rd0_reg;
    assign mid      = sel_reg ? rd0_reg : rd1_reg;
    assign clr_busy = clr_busy_reg;

endmodule

`default_nettype wire

[hw/rtl/lbphe_code.sv]
`default_nettype none

module lbphe_code
    import lbphe_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire push_t      push,
    input  wire logic [7:0] top,
    input  wire logic [7:0] mid,
    input  wire logic       uniform_mode,
    output hist_upd_t       upd
);

    logic [7:0] win_reg [6];
    logic       upd_vld_reg;
    logic [7:0] upd_bin_reg;

    logic [7:0] c;
    logic [7:0] code;
    logic [7:0] bin;

    always_comb begin
        c       = win_reg[4];
        code[0] = mid > c;
        code[1] = push.px > c;
        code[2] = win_reg[5] > c;
        code[3] = win_reg[2] > c;
        code[4] = win_reg[1] > c;
        code[5] = win_reg[0] > c;
        code[6] = win_reg[3] > c;
        code[7] = top > c;
        bin     = uniform_mode ? uniform_bin(code) : code;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 6; k++) begin
                win_reg[k] <= 8'd0;
            end
            upd_vld_reg <= 1'b0;
        end else begin
            upd_vld_reg <= push.vld && push.interior;
            if (push.vld) begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top;
                win_reg[4] <= mid;
                win_reg[5] <= push.px;
            end
        end
    end

    always_ff @(posedge aclk) begin
        upd_bin_reg <= bin;
    end

    assign upd.vld = upd_vld_reg;
    assign upd.bin = upd_bin_reg;

endmodule

`default_nettype wire

[hw/rtl/lbphe_hist.sv]
`default_nettype none

module lbphe_hist
    import lbphe_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire hist_upd_t             upd,
    input  wire logic                  rd_en,
    input  wire logic [7:0]            rd_idx,
    input  wire logic                  clear,
    output logic [COUNT_BITS-1:0]      rd_count,
    output logic                       busy
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [COUNT_BITS-1:0] cnt_mem [256];
    logic [255:0]          ent_vld_reg;

    logic [COUNT_BITS-1:0] rd_reg;
    logic                  rd_vld_reg;
    logic                  d_vld_reg;
    logic [7:0]            d_bin_reg;
    logic                  fwd_vld_reg;
    logic [7:0]            fwd_bin_reg;
    logic [COUNT_BITS-1:0] fwd_cnt_reg;

    logic [7:0]            raddr;
    logic [COUNT_BITS-1:0] stored;
    logic [COUNT_BITS-1:0] old_cnt;
    logic [COUNT_BITS-1:0] new_cnt;

    assign raddr  = rd_en ? rd_idx : upd.bin;
    assign stored = rd_vld_reg ? rd_reg : '0;

    // The write of the previous cycle is not yet visible in the read data.
    always_comb begin
        old_cnt = (fwd_vld_reg && fwd_bin_reg == d_bin_reg) ? fwd_cnt_reg : stored;
        new_cnt = (old_cnt != CNT_MAX) ? old_cnt + COUNT_BITS'(1) : old_cnt;
    end

    always_ff @(posedge aclk) begin
        if (d_vld_reg) begin
            cnt_mem[d_bin_reg] <= new_cnt;
        end
        rd_reg <= cnt_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
            d_vld_reg   <= 1'b0;
            fwd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg  <= ent_vld_reg[raddr];
            d_vld_reg   <= upd.vld;
            fwd_vld_reg <= d_vld_reg && !clear;
            if (clear) begin
                ent_vld_reg <= '0;
            end else if (d_vld_reg) begin
                ent_vld_reg[d_bin_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        d_bin_reg   <= upd.bin;
        fwd_bin_reg <= d_bin_reg;
        fwd_cnt_reg <= new_cnt;
    end

    assign rd_count = stored;
    assign busy     = d_vld_reg;

endmodule

`default_nettype wire

[hw/rtl/lbp_histogram_engine_unit.sv]
`default_nettype none

// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      s_action, s_pixel, s_bin_index
// m_        out        m_valid / m_ready      m_bin_count, m_frame_complete
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A push is taken every cycle but during the reset sweep; its increment passes the push
// register, the code stage and the hist update register to the histogram memory, with
// forwarding between back-to-back updates of one bin. A read or a clear waits until that
// pipeline has drained; a read's count passes the hist read register to the m_ output
// register, and a second read waits until that is emptied. Pushes continue while a count
// waits. After reset the line store is swept to zero with s_ready low.
module lbp_histogram_engine_unit
    import lbphe_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_action,
    input  wire logic [7:0]          s_pixel,
    input  wire logic [7:0]          s_bin_index,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [OUT_BITS-1:0]      m_bin_count,
    output logic                     m_frame_complete,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [10:0]         cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    logic [10:0]   fw_reg;
    logic [10:0]   fh_reg;
    logic          uni_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;

    push_t         b_reg;
    logic          r_vld_reg;
    logic          r_inrange_reg;
    logic          r_done_reg;
    logic          m_valid_reg;
    logic [OUT_BITS-1:0] m_count_reg;
    logic          m_done_reg;

    logic [SIZE_BITS-1:0] w_eff;
    logic [SIZE_BITS-1:0] h_eff;
    logic          frame_done;
    logic          accept;
    logic          push_go;
    logic          read_go;
    logic          clear_go;
    logic          pipe_empty;
    logic          clr_busy;
    logic [7:0]    top;
    logic [7:0]    mid;
    hist_upd_t     upd;
    logic          hist_busy;
    logic [COUNT_BITS-1:0] hist_count;
    logic [32:0]   count_ext;
    logic [OUT_BITS-1:0] m_count_next;

    always_comb begin
        w_eff = SIZE_BITS'(fw_reg);
        if (w_eff < SIZE_BITS'(3)) begin
            w_eff = SIZE_BITS'(3);
        end else if (w_eff > SIZE_BITS'(MAX_WIDTH)) begin
            w_eff = SIZE_BITS'(MAX_WIDTH);
        end
        h_eff = SIZE_BITS'(fh_reg);
        if (h_eff < SIZE_BITS'(3)) begin
            h_eff = SIZE_BITS'(3);
        end else if (h_eff > SIZE_BITS'(MAX_HEIGHT)) begin
            h_eff = SIZE_BITS'(MAX_HEIGHT);
        end
    end

    assign frame_done = SIZE_BITS'(row_reg) >= h_eff;
    assign pipe_empty = !b_reg.vld && !upd.vld && !hist_busy;

    always_comb begin
        s_ready = 1'b0;
        if (!clr_busy) begin
            case (s_action)
                ACT_READ:  s_ready = pipe_empty && !r_vld_reg && !m_valid_reg;
                ACT_CLEAR: s_ready = pipe_empty;
                default:   s_ready = 1'b1;
            endcase
        end
    end

    assign accept   = s_valid && s_ready;
    assign push_go  = accept && s_action == ACT_PUSH && !frame_done;
    assign read_go  = accept && s_action == ACT_READ;
    assign clear_go = accept && s_action == ACT_CLEAR;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg  <= 11'd64;
            fh_reg  <= 11'd64;
            uni_reg <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  fw_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: fh_reg  <= cfg_data;
                CFG_UNIFORM_MODE: uni_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (clear_go) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (push_go) begin
            if (SIZE_BITS'(col_reg) + SIZE_BITS'(1) >= w_eff) begin
                col_reg <= '0;
                row_reg <= row_reg + RW'(1);
            end else begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_reg.vld <= 1'b0;
        end else begin
            b_reg.vld <= push_go;
        end
        b_reg.interior <= row_reg >= RW'(2) && col_reg >= CW'(2);
        b_reg.px       <= s_pixel;
    end

    lbphe_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (push_go),
        .sel      (row_reg[0]),
        .col      (col_reg),
        .px       (s_pixel),
        .top      (top),
        .mid      (mid),
        .clr_busy (clr_busy)
    );

    lbphe_code u_code (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (b_reg),
        .top          (top),
        .mid          (mid),
        .uniform_mode (uni_reg),
        .upd          (upd)
    );

    lbphe_hist #(
        .COUNT_BITS (COUNT_BITS)
    ) u_hist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .upd      (upd),
        .rd_en    (read_go),
        .rd_idx   (s_bin_index),
        .clear    (clear_go),
        .rd_count (hist_count),
        .busy     (hist_busy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_vld_reg <= 1'b0;
        end else begin
            r_vld_reg <= read_go;
        end
    end

    always_ff @(posedge aclk) begin
        r_inrange_reg <= !uni_reg || s_bin_index < UNI_BINS;
        r_done_reg    <= frame_done;
    end

    always_comb begin
        count_ext = 33'(hist_count);
        if (!r_inrange_reg) begin
            m_count_next = '0;
        end else if (count_ext > 33'(OUT_COUNT_MAX)) begin
            m_count_next = OUT_COUNT_MAX;
        end else begin
            m_count_next = count_ext[OUT_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (r_vld_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (r_vld_reg) begin
            m_count_reg <= m_count_next;
            m_done_reg  <= r_done_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_bin_count      = m_count_reg;
    assign m_frame_complete = m_done_reg;

endmodule

`default_nettype wire

[dv/lbp_histogram_engine_unit_tb.sv]
`default_nettype none

module lbp_histogram_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lbphe_pkg::*;

    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int unsigned MAXW         = MAX_WIDTH_DEF;
    localparam int unsigned MAXH         = MAX_HEIGHT_DEF;
    localparam int unsigned MIN_DIM      = 3;
    localparam int unsigned HIST_MAX     = (1 << COUNT_BITS_DEF) - 1;
    localparam logic [1:0]  ACT_NONE     = 2'd3;

    typedef struct {
        logic [1:0] action;
        logic [7:0] pixel;
        logic [7:0] bin_index;
    } lbp_req_t;

    typedef struct {
        logic [OUT_BITS-1:0] count;
        logic                done;
    } bin_reply_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [1:0]          s_action = ACT_PUSH;
    logic [7:0]          s_pixel = 8'd0;
    logic [7:0]          s_bin_index = 8'd0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [OUT_BITS-1:0] m_bin_count;
    logic                m_frame_complete;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = CFG_FRAME_WIDTH;
    logic [10:0]         cfg_data = 11'd0;

    lbp_req_t   req_fifo[$];
    bin_reply_t read_returns[$];
    int         items_left = 0;
    int         errors = 0;
    int         cycle_count = 0;
    int         send_idle = 0;
    int         recv_stall = 0;

    // Shadow of the block: configuration, line store, window, position and histogram.
    logic [10:0] frame_w = 11'd64;
    logic [10:0] frame_h = 11'd64;
    logic        uni_mode = 1'b1;
    bit [7:0]    line_mem [2*MAXW];
    bit [7:0]    win [6];
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;
    int unsigned hist [256];

    lbp_histogram_engine_unit u_top (.*);

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic int unsigned clamp_dim(input logic [10:0] v, input int unsigned lim);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > lim) return lim;
        return v;
    endfunction

    // A code is uniform when it has exactly two 0/1 transitions around the circle; its bin
    // is then given by where the run of ones starts and how long it is.
    function automatic logic [7:0] u2_bin_of(input logic [7:0] code);
        int ones;
        int flips;
        int start;
        ones = 0;
        flips = 0;
        start = 0;
        for (int k = 0; k < 8; k++) begin
            ones += code[k];
            if (code[k] != code[(k + 1) % 8]) flips++;
            if (code[k] && !code[(k + 7) % 8]) start = k;
        end
        if (ones == 0 || ones == 8) return BIN_FLAT;
        if (flips != 2) return BIN_NONUNI;
        return 8'(start * RUN_LEN_MAX + ones - 1);
    endfunction

    function automatic void histo_update(input lbp_req_t req);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned row;
        int unsigned older;
        int unsigned newer;
        int unsigned nbins;
        int unsigned cnt;
        logic [7:0]  top;
        logic [7:0]  mid;
        logic [7:0]  ctr;
        logic [7:0]  code;
        logic [7:0]  bin;
        bin_reply_t  rep;
        case (req.action)
            ACT_PUSH: begin
                w = clamp_dim(frame_w, MAXW);
                h = clamp_dim(frame_h, MAXH);
                col = col_pos % MAXW;
                row = row_pos;
                if (row < h) begin
                    older = (row % 2) * MAXW + col;
                    newer = ((row + 1) % 2) * MAXW + col;
                    top = line_mem[older];
                    mid = line_mem[newer];
                    if (row >= 2 && col >= 2) begin
                        ctr = win[4];
                        code = {top > ctr, win[3] > ctr, win[0] > ctr, win[1] > ctr,
                                win[2] > ctr, win[5] > ctr, req.pixel > ctr, mid > ctr};
                        bin = uni_mode ? u2_bin_of(code) : code;
                        if (hist[bin] < HIST_MAX) hist[bin]++;
                    end
                    win[0] = win[3];
                    win[1] = win[4];
                    win[2] = win[5];
                    win[3] = top;
                    win[4] = mid;
                    win[5] = req.pixel;
                    line_mem[older] = req.pixel;
                    if (col + 1 >= w) begin
                        col_pos = 0;
                        row_pos = row + 1;
                    end else begin
                        col_pos = col + 1;
                    end
                end
            end
            ACT_READ: begin
                nbins = uni_mode ? UNI_BINS : 256;
                cnt = (req.bin_index < nbins) ? hist[req.bin_index] : 0;
                rep.count = (cnt > OUT_COUNT_MAX) ? OUT_COUNT_MAX : cnt[OUT_BITS-1:0];
                rep.done = (row_pos >= clamp_dim(frame_h, MAXH));
                read_returns.push_back(rep);
            end
            ACT_CLEAR: begin
                foreach (hist[i]) hist[i] = 0;
                col_pos = 0;
                row_pos = 0;
            end
            default: ;
        endcase
    endfunction

    always @(posedge aclk) begin : req_driver
        lbp_req_t acc;
        lbp_req_t nxt;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                acc.action = s_action;
                acc.pixel = s_pixel;
                acc.bin_index = s_bin_index;
                histo_update(acc);
                items_left--;
            end
            if (!s_valid || s_ready) begin
                if (req_fifo.size() != 0 && $urandom_range(99) >= send_idle) begin
                    nxt = req_fifo.pop_front();
                    s_valid <= 1'b1;
                    s_action <= nxt.action;
                    s_pixel <= nxt.pixel;
                    s_bin_index <= nxt.bin_index;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : reply_monitor
        bin_reply_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (read_returns.size() == 0) begin
                    flag_mismatch($sformatf("count %0d done %0b with no read outstanding",
                                            m_bin_count, m_frame_complete));
                end else begin
                    want = read_returns.pop_front();
                    if (m_bin_count !== want.count || m_frame_complete !== want.done) begin
                        flag_mismatch($sformatf("count %0d done %0b, wanted %0d done %0b",
                                                m_bin_count, m_frame_complete,
                                                want.count, want.done));
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic post_req(input logic [1:0] action, input logic [7:0] pixel,
                            input logic [7:0] bin_index);
        lbp_req_t req;
        req.action = action;
        req.pixel = pixel;
        req.bin_index = bin_index;
        items_left++;
        req_fifo.push_back(req);
    endtask

    task automatic wait_idle();
        while (items_left != 0 || read_returns.size() != 0) @(posedge aclk);
        // Pushes produce no reply, so give the increment pipeline time to settle.
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_frame(input logic [10:0] w, input logic [10:0] h, input logic uni);
        logic [10:0] vals [3];
        logic [1:0]  regs [3];
        vals = '{w, h, {10'd0, uni}};
        regs = '{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_UNIFORM_MODE};
        cfg_valid <= 1'b1;
        for (int i = 0; i < 3; i++) begin
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_w = cfg_data;
                CFG_FRAME_HEIGHT: frame_h = cfg_data;
                CFG_UNIFORM_MODE: uni_mode = cfg_data[0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Narrow ranges make ties with the centre and smooth, uniform-looking codes common.
    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(2))
            0: return 8'($urandom);
            1: return 8'($urandom_range(3));
            default: return 8'(252 + $urandom_range(3));
        endcase
    endfunction

    task automatic random_traffic(input int n_items);
        int roll;
        repeat (n_items) begin
            roll = $urandom_range(99);
            if (roll < 72) begin
                post_req(ACT_PUSH, rand_pixel(), 8'($urandom));
            end else if (roll < 95) begin
                post_req(ACT_READ, 8'($urandom),
                         (uni_mode && $urandom_range(3) != 0) ? 8'($urandom_range(63))
                                                               : 8'($urandom));
            end else if (roll < 96) begin
                post_req(ACT_CLEAR, 8'($urandom), 8'($urandom));
            end else begin
                post_req(ACT_NONE, 8'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        logic [10:0] w;
        logic [10:0] h;
        logic [7:0]  dir_px [9];
        // Centre 100 with only E and SE above it, S equal: a run of two ones from bit 0.
        dir_px = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd100, 8'd255, 8'd0, 8'd100, 8'd255};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        post_req(ACT_READ, 8'd0, 8'd0);
        wait_idle();

        set_frame(11'd3, 11'd3, 1'b1);
        foreach (dir_px[i]) post_req(ACT_PUSH, dir_px[i], 8'd0);
        post_req(ACT_READ, 8'd0, 8'd1);
        post_req(ACT_READ, 8'd0, BIN_FLAT);
        post_req(ACT_READ, 8'd0, BIN_NONUNI);
        post_req(ACT_READ, 8'd0, UNI_BINS);
        post_req(ACT_READ, 8'd0, 8'd255);
        post_req(ACT_PUSH, 8'd255, 8'd0);
        post_req(ACT_NONE, 8'd255, 8'd255);
        post_req(ACT_CLEAR, 8'd0, 8'd0);
        post_req(ACT_READ, 8'd0, 8'd1);
        wait_idle();

        // Widest frame, raw codes: fill one full row and start the next.
        set_frame(11'd2047, 11'd0, 1'b0);
        post_req(ACT_CLEAR, 8'd0, 8'd0);
        repeat (MAXW + 6) post_req(ACT_PUSH, rand_pixel(), 8'd0);
        repeat (4) post_req(ACT_READ, 8'd0, 8'($urandom));
        wait_idle();

        // The width now falls below the column reached, so the next item wraps the row.
        set_frame(11'd5, 11'd3, 1'b0);
        repeat (8) post_req(ACT_PUSH, rand_pixel(), 8'd0);
        repeat (6) post_req(ACT_READ, 8'd0, 8'($urandom));
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            w = 11'($urandom_range(6));
            h = 11'($urandom_range(6));
            if (p == 3) begin
                w = 11'd3;
                h = 11'd1024;
            end
            if (p == 6) begin
                w = 11'd4;
                h = 11'd2047;
            end
            case (p % 4)
                0: begin
                    send_idle = 0;
                    recv_stall = 0;
                end
                1: begin
                    send_idle = 64;
                    recv_stall = 0;
                end
                2: begin
                    send_idle = 0;
                    recv_stall = 64;
                end
                default: begin
                    send_idle = 17;
                    recv_stall = 17;
                end
            endcase
            set_frame(w, h, p % 3 != 0);
            // One phase carries on with the frame position left by the one before.
            if (p != 5) post_req(ACT_CLEAR, 8'd0, 8'd0);
            random_traffic(35);
            wait_idle();
        end

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
